### src/grsd_pkg.sv
`default_nettype none

package grsd_pkg;

  localparam int GRSD_MAX_SIDE = 32;

  localparam logic [5:0] GRID_SIZE_RESET = 6'd32;
  localparam logic [4:0] DAY_MAX         = 5'd31;

  localparam logic [1:0] KIND_ROTTEN = 2'd0;
  localparam logic [1:0] KIND_FRESH  = 2'd1;

  typedef struct packed {
    logic [1:0] cell_kind;
    logic       last_cell;
  } in_beat_t;

  typedef struct packed {
    logic [4:0] day_count;
    logic       never_done;
  } out_beat_t;

endpackage

`default_nettype wire

### src/grid_rot_spread_day_counter_unit.sv
`default_nettype none

// Channel  Direction  Handshake            Beat
// in       input      in_valid/in_ready    in_data  (cell_kind, last_cell)
// out      output     out_valid/out_ready  out_data (day_count, never_done)
// cfg      input      cfg_wr_en            cfg_wr_data (grid_size), no wait
//
// Loading: a cell in the row held by the load buffer is placed there directly;
// for a new row the buffer is written back and the row fetched from the row RAM.
// After a side change mid-grid, row/column are re-derived by bit-serial division.
// Evaluation after the last cell: a flush state, then per day one RAM read per
// row, streamed through a three-row window, then a decide state.
// Reset is synchronous; the row RAM needs no clearing, per-row valid bits
// are dropped at the first cell of each grid. A held result does not stall
// input; only the next result waits on out_ready.

module grid_rot_spread_day_counter_unit #(
  parameter int MAX_SIDE = grsd_pkg::GRSD_MAX_SIDE
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire grsd_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output grsd_pkg::out_beat_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [5:0]          cfg_wr_data
);

  import grsd_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int RW    = $clog2(MAX_SIDE);
  localparam int PW    = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int TW    = 2 * SW;
  localparam int DCW   = $clog2(PW + 1);
  localparam int GUARD = 2 * MAX_SIDE;
  localparam int GW    = $clog2(GUARD + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_PLACE, ST_FETCH, ST_FLUSH, ST_DAY, ST_DECIDE, ST_DONE
  } state_t;

  function automatic logic [MAX_SIDE-1:0] hdil(input logic [MAX_SIDE-1:0] x,
                                               input logic [MAX_SIDE-1:0] m);
    hdil = (x | (x << 1) | (x >> 1)) & m;
  endfunction

  state_t state;

  logic [5:0]          grid_size;
  logic [SW-1:0]       side;
  logic [1:0]          kind_l;
  logic                last_l;
  logic [SW-1:0]       n_l;
  logic [SW-1:0]       trk_n;
  logic [PW-1:0]       pos;
  logic [RW-1:0]       row;
  logic [RW-1:0]       col;
  logic [MAX_SIDE-1:0] buf_rot;
  logic [MAX_SIDE-1:0] buf_fr;
  logic [RW-1:0]       buf_row;
  logic [MAX_SIDE-1:0] row_ok;

  logic [DCW-1:0]      div_cnt;
  logic [SW-1:0]       rem;
  logic [PW-1:0]       quo;
  logic [PW-1:0]       dvd;

  logic [SW-1:0]       ri;
  logic                rd_pend;
  logic [RW-1:0]       rd_row;
  logic                have_p1;
  logic [RW-1:0]       p1_row;
  logic [MAX_SIDE-1:0] p0_rot;
  logic [MAX_SIDE-1:0] p1_rot;
  logic [MAX_SIDE-1:0] p1_fr;
  logic                init_rot;
  logic                init_fr;
  logic                fresh_acc;
  logic                first_day;
  logic [GW-1:0]       iter;
  logic [4:0]          days;
  logic                never_l;

  logic [MAX_SIDE-1:0]   cm;
  logic [TW-1:0]         total;
  logic                  in_grid;
  logic                  more;
  logic                  col_end;
  logic                  row_miss;
  logic [MAX_SIDE-1:0]   colbit;
  logic [MAX_SIDE-1:0]   set_rot;
  logic [MAX_SIDE-1:0]   set_fr;
  logic [SW:0]           rem_sh;
  logic                  div_ge;
  logic [SW:0]           rem_nx;
  logic [PW-1:0]         quo_nx;
  logic [MAX_SIDE-1:0]   in_rot;
  logic [MAX_SIDE-1:0]   in_fr;
  logic [MAX_SIDE-1:0]   new_rot;
  logic [MAX_SIDE-1:0]   new_fr;
  logic [GW-1:0]         iter_nx;
  logic [4:0]            days_nx;

  logic                  ram_wr_en;
  logic [RW-1:0]         ram_wr_addr;
  logic [2*MAX_SIDE-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [RW-1:0]         ram_rd_addr;
  logic [2*MAX_SIDE-1:0] ram_rd_data;

  always_comb begin
    if (grid_size == 6'd0) begin
      side = SW'(1);
    end else if (7'(grid_size) > 7'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(grid_size);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      cm[i] = SW'(i) < n_l;
    end
  end

  assign total    = TW'(n_l) * TW'(n_l);
  assign in_grid  = TW'(pos) < total;
  assign more     = !last_l && ((TW'(pos) + TW'(1)) < total);
  assign col_end  = (SW'(col) + SW'(1)) == n_l;
  assign row_miss = in_grid && (row != buf_row);
  assign colbit   = MAX_SIDE'(1) << col;
  assign set_rot  = (in_grid && kind_l == KIND_ROTTEN) ? colbit : '0;
  assign set_fr   = (in_grid && kind_l == KIND_FRESH) ? colbit : '0;

  assign rem_sh = {rem, dvd[PW-1]};
  assign div_ge = rem_sh >= {1'b0, n_l};
  assign rem_nx = div_ge ? (rem_sh - {1'b0, n_l}) : rem_sh;
  assign quo_nx = {quo[PW-2:0], div_ge};

  assign in_rot  = (rd_pend && row_ok[rd_row]) ? (ram_rd_data[2*MAX_SIDE-1:MAX_SIDE] & cm)
                                               : '0;
  assign in_fr   = (rd_pend && row_ok[rd_row]) ? (ram_rd_data[MAX_SIDE-1:0] & cm) : '0;
  assign new_rot = hdil(p0_rot, cm) | hdil(p1_rot, cm) | hdil(in_rot, cm);
  assign new_fr  = p1_fr & ~new_rot;

  assign iter_nx = iter + GW'(1);
  assign days_nx = (days == DAY_MAX) ? days : days + 5'd1;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = buf_row;
    ram_wr_data = {buf_rot, buf_fr};
    ram_rd_en   = 1'b0;
    ram_rd_addr = row;
    unique case (state)
      ST_PLACE: begin
        ram_wr_en = row_miss;
        ram_rd_en = row_miss;
      end
      ST_FLUSH: begin
        ram_wr_en = 1'b1;
      end
      ST_DAY: begin
        ram_wr_en   = have_p1;
        ram_wr_addr = p1_row;
        ram_wr_data = {new_rot, new_fr};
        ram_rd_en   = ri < n_l;
        ram_rd_addr = RW'(ri);
      end
      default: begin
      end
    endcase
  end

  assign in_ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grid_size <= GRID_SIZE_RESET;
      pos       <= '0;
      row_ok    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_size <= cfg_wr_data;
      end
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_l <= in_data.cell_kind;
            last_l <= in_data.last_cell;
            n_l    <= side;
            if (pos == '0) begin
              row     <= '0;
              col     <= '0;
              trk_n   <= side;
              buf_rot <= '0;
              buf_fr  <= '0;
              buf_row <= '0;
              row_ok  <= '0;
              state   <= ST_PLACE;
            end else if (side != trk_n) begin
              dvd     <= pos;
              rem     <= '0;
              quo     <= '0;
              div_cnt <= '0;
              state   <= ST_DIV;
            end else begin
              state <= ST_PLACE;
            end
          end
        end

        ST_DIV: begin
          dvd     <= dvd << 1;
          rem     <= rem_nx[SW-1:0];
          quo     <= quo_nx;
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(PW - 1)) begin
            row   <= quo_nx[RW-1:0];
            col   <= rem_nx[RW-1:0];
            trk_n <= n_l;
            state <= ST_PLACE;
          end
        end

        ST_PLACE, ST_FETCH: begin
          if (state == ST_PLACE && row_miss) begin
            row_ok[buf_row] <= 1'b1;
            state           <= ST_FETCH;
          end else begin
            if (state == ST_FETCH) begin
              buf_row <= row;
              buf_rot <= (row_ok[row] ? ram_rd_data[2*MAX_SIDE-1:MAX_SIDE] : '0) | set_rot;
              buf_fr  <= (row_ok[row] ? ram_rd_data[MAX_SIDE-1:0] : '0) | set_fr;
            end else begin
              buf_rot <= buf_rot | set_rot;
              buf_fr  <= buf_fr | set_fr;
            end
            if (more) begin
              pos <= pos + PW'(1);
              if (col_end) begin
                col <= '0;
                row <= row + RW'(1);
              end else begin
                col <= col + RW'(1);
              end
              state <= ST_IDLE;
            end else begin
              pos   <= '0;
              state <= ST_FLUSH;
            end
          end
        end

        ST_FLUSH: begin
          row_ok[buf_row] <= 1'b1;
          ri        <= '0;
          rd_pend   <= 1'b0;
          have_p1   <= 1'b0;
          p0_rot    <= '0;
          p1_rot    <= '0;
          fresh_acc <= 1'b0;
          init_rot  <= 1'b0;
          init_fr   <= 1'b0;
          first_day <= 1'b1;
          iter      <= '0;
          days      <= '0;
          never_l   <= 1'b0;
          state     <= ST_DAY;
        end

        ST_DAY: begin
          if (ri < n_l) begin
            ri      <= ri + SW'(1);
            rd_pend <= 1'b1;
            rd_row  <= RW'(ri);
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend || have_p1) begin
            if (have_p1) begin
              row_ok[p1_row] <= 1'b1;
              fresh_acc      <= fresh_acc | (|new_fr);
            end
            init_rot <= init_rot | (|in_rot);
            init_fr  <= init_fr | (|in_fr);
            p0_rot   <= p1_rot;
            p1_rot   <= in_rot;
            p1_fr    <= in_fr;
            p1_row   <= rd_row;
            have_p1  <= rd_pend;
          end
          if (!rd_pend && have_p1) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (first_day && !init_fr) begin
            state <= ST_DONE;
          end else if (first_day && !init_rot) begin
            never_l <= 1'b1;
            state   <= ST_DONE;
          end else begin
            iter      <= iter_nx;
            days      <= days_nx;
            first_day <= 1'b0;
            if (!fresh_acc || iter_nx == GW'(GUARD)) begin
              state <= ST_DONE;
            end else begin
              ri        <= '0;
              p0_rot    <= '0;
              fresh_acc <= 1'b0;
              state     <= ST_DAY;
            end
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.day_count  <= days;
            out_data.never_done <= never_l;
            state               <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  grsd_ram #(
    .WIDTH (2 * MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

### src/grsd_ram.sv
`default_nettype none

module grsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### tb/grsd_day_checker.sv
module grsd_day_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  grsd_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  grsd_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [5:0]          cfg_wr_data,
  output int                  outstanding,
  output int                  mismatch_total
);
  timeunit 1ns;
  timeprecision 1ps;
  import grsd_pkg::*;

  logic [63:0] rot_rows   [GRSD_MAX_SIDE];
  logic [63:0] fresh_rows [GRSD_MAX_SIDE];
  int unsigned load_pos;
  logic [5:0]  side_reg;
  out_beat_t   due_days_q[$];
  int          err_count;

  initial begin
    outstanding    = 0;
    mismatch_total = 0;
    err_count      = 0;
    load_pos       = 0;
    side_reg       = GRID_SIZE_RESET;
  end

  always @(posedge clk) begin
    int unsigned n, total, pos, row, col;
    logic [63:0] rot  [GRSD_MAX_SIDE];
    logic [63:0] fr   [GRSD_MAX_SIDE];
    logic [63:0] halo [GRSD_MAX_SIDE];
    logic [63:0] cm, v, any_rot, any_fr;
    out_beat_t   days, got;
    if (rst) begin
      side_reg = GRID_SIZE_RESET;
      load_pos = 0;
      due_days_q.delete();
    end else begin
      if (cfg_wr_en) side_reg = cfg_wr_data;

      if (in_valid && in_ready) begin
        // side is clamped to 1..MAX and read anew for every beat
        if (side_reg == 6'd0) n = 1;
        else if (side_reg > GRSD_MAX_SIDE) n = GRSD_MAX_SIDE;
        else n = side_reg;
        total = n * n;
        pos   = load_pos;
        if (pos == 0) begin
          for (int r = 0; r < GRSD_MAX_SIDE; r++) begin
            rot_rows[r]   = '0;
            fresh_rows[r] = '0;
          end
        end
        if (pos < total) begin
          row = pos / n;
          col = pos % n;
          if (in_data.cell_kind == KIND_ROTTEN) rot_rows[row][col] = 1'b1;
          else if (in_data.cell_kind == KIND_FRESH) fresh_rows[row][col] = 1'b1;
        end

        if (!in_data.last_cell && pos + 1 < total) begin
          load_pos = pos + 1;
        end else begin
          load_pos = 0;
          days     = '0;
          cm       = (64'd1 << n) - 64'd1;
          any_rot  = '0;
          any_fr   = '0;
          for (int r = 0; r < n; r++) begin
            rot[r]  = rot_rows[r] & cm;
            fr[r]   = fresh_rows[r] & cm;
            any_rot |= rot[r];
            any_fr  |= fr[r];
          end
          if (any_fr != '0 && any_rot == '0) begin
            days.never_done = 1'b1;
          end else begin
            // one day = 3x3 dilation of the rotten set
            for (int g = 0; g < 2 * GRSD_MAX_SIDE && any_fr != '0; g++) begin
              for (int r = 0; r < n; r++)
                halo[r] = (rot[r] | (rot[r] << 1) | (rot[r] >> 1)) & cm;
              any_fr = '0;
              for (int r = 0; r < n; r++) begin
                v = halo[r];
                if (r > 0) v |= halo[r - 1];
                if (r + 1 < n) v |= halo[r + 1];
                rot[r] = v;
                fr[r]  &= ~v;
                any_fr |= fr[r];
              end
              if (days.day_count != DAY_MAX) days.day_count = days.day_count + 5'd1;
            end
          end
          due_days_q.push_back(days);
        end
      end

      if (out_valid && out_ready) begin
        got = out_data;
        if (due_days_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("[%0t] unexpected result beat: day_count %0d never_done %0d",
                     $realtime, got.day_count, got.never_done);
        end else begin
          days = due_days_q.pop_front();
          if (got.day_count !== days.day_count) begin
            err_count++;
            if (err_count <= 10)
              $display("[%0t] day_count mismatch: expected %0d, got %0d",
                       $realtime, days.day_count, got.day_count);
          end
          if (got.never_done !== days.never_done) begin
            err_count++;
            if (err_count <= 10)
              $display("[%0t] never_done mismatch: expected %0d, got %0d",
                       $realtime, days.never_done, got.never_done);
          end
        end
      end
    end
    outstanding    <= due_days_q.size();
    mismatch_total <= err_count;
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grsd_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TARGET_CELLS = 1950;

  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic      clk         = 1'b0;
  logic      rst         = 1'b1;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_beat_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  int outstanding;
  int mismatch_total;
  int cells_sent   = 0;
  int cycle_count  = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int grid_side    = 32;
  bit quiet        = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  grid_rot_spread_day_counter_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  grsd_day_checker day_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .outstanding    (outstanding),
    .mismatch_total (mismatch_total)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random backpressure, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
      end
    end
  end

  function automatic logic [1:0] rand_kind();
    int r;
    r = $urandom_range(99);
    if (r < 15) return KIND_ROTTEN;
    if (r < 60) return KIND_FRESH;
    if (r < 88) return KIND_OTHER;
    return KIND_SPARE;
  endfunction

  function automatic logic [5:0] random_side();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 6'($urandom_range(8, 1));
    if (r < 82) return 6'($urandom_range(20, 9));
    if (r < 94) return 6'($urandom_range(32, 21));
    return $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, 33));
  endfunction

  task automatic send_cell(input logic [1:0] kind, input logic last);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cell_kind: kind, last_cell: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cells_sent++;
  endtask

  // drop valid and wait until every grid result is back and loading has settled
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic set_size(input logic [5:0] sz);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    if (sz == 6'd0) grid_side = 1;
    else if (sz > GRSD_MAX_SIDE) grid_side = GRSD_MAX_SIDE;
    else grid_side = sz;
  endtask

  initial begin
    int  total, len, k, p;
    bit  sparse, end_mark;
    logic [1:0] kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    set_size(6'd32);
    send_cell(KIND_ROTTEN, 1'b0);
    send_cell(KIND_FRESH, 1'b1);
    set_size(6'd1);
    send_cell(KIND_FRESH, 1'b0);
    send_cell(KIND_ROTTEN, 1'b1);
    send_cell(KIND_SPARE, 1'b0);
    send_cell(KIND_OTHER, 1'b1);
    set_size(6'd0);
    send_cell(KIND_FRESH, 1'b1);
    set_size(6'd63);
    send_cell(KIND_ROTTEN, 1'b0);
    send_cell(KIND_OTHER, 1'b0);
    send_cell(KIND_FRESH, 1'b1);
    set_size(6'd2);
    repeat (4) send_cell(KIND_OTHER, 1'b0);
    set_size(6'd3);
    send_cell(KIND_ROTTEN, 1'b0);
    repeat (4) send_cell(KIND_FRESH, 1'b0);
    set_size(6'd2);   // load position already past the smaller grid
    send_cell(KIND_FRESH, 1'b0);
    set_size(6'd4);
    send_cell(KIND_FRESH, 1'b0);
    send_cell(KIND_FRESH, 1'b0);
    send_cell(KIND_ROTTEN, 1'b0);
    set_size(6'd2);   // shrink mid-grid, next cell still fits
    send_cell(KIND_FRESH, 1'b0);

    // random
    while (cells_sent < TARGET_CELLS) begin
      quiet = (cells_sent >= 900 && cells_sent < 1250);

      if (holds_asked < 2 && cells_sent >= (holds_asked == 0 ? 450 : 1500)) begin
        set_size(6'd1);
        holds_asked++;
        repeat (24) send_cell(rand_kind(), 1'($urandom_range(1)));
      end

      if ($urandom_range(99) < 40) set_size(random_side());
      total = grid_side * grid_side;
      p = $urandom_range(99);

      if (p < 10) begin
        // partial grid, then a side change mid-load
        k = $urandom_range(total < 40 ? total : 40, 1);
        repeat (k) send_cell(rand_kind(), 1'b0);
        set_size(random_side());
      end else if (p < 20) begin
        k = $urandom_range(30, 1);
        repeat (k) send_cell(rand_kind(), 1'($urandom_range(99) < 10));
      end else begin
        sparse = ($urandom_range(99) < 25);
        if (total <= 200 && $urandom_range(1)) begin
          len      = total;
          end_mark = $urandom_range(1);
        end else begin
          len      = $urandom_range(total < 200 ? total : 200, 1);
          end_mark = 1'b1;
        end
        for (int i = 0; i < len; i++) begin
          if (!sparse) kind = rand_kind();
          else if (i == 0) kind = KIND_ROTTEN;
          else if (i == len - 1) kind = KIND_FRESH;
          else kind = ($urandom_range(99) < 5) ? rand_kind() : KIND_OTHER;
          send_cell(kind, (i == len - 1) && end_mark);
        end
      end
    end

    settle();
    repeat (64) @(posedge clk);
    if (mismatch_total == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/grsd_pkg.sv
src/grsd_ram.sv
src/grid_rot_spread_day_counter_unit.sv
tb/grsd_day_checker.sv
tb/tb.sv
